[rtl/tpt_pkg.sv]
// ============================================================================
// tpt_pkg
// Shared types, constants and address helpers for the TLB / page table
// translate unit.
// ============================================================================
package tpt_pkg;

    // Geometry
    localparam int TLB_ENTRIES = 16;
    localparam int OFFSET_BITS = 8;
    localparam int PAGE_BITS   = 8;
    localparam int ADDR_W      = 16;

    localparam int NUM_PAGES   = 1 << PAGE_BITS;
    localparam int FILL_W      = $clog2(TLB_ENTRIES + 1);
    localparam int FREE_W      = PAGE_BITS + 1;
    localparam int WIDE_W      = ADDR_W + PAGE_BITS + OFFSET_BITS;

    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [FILL_W-1:0]    fill_t;
    typedef logic [FREE_W-1:0]    free_t;

    // Control FSM of the top level
    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } tpt_state_t;

    // Compare result of one TLB cell
    typedef struct packed {
        logic  match;
        page_t frame;
    } tpt_cell_res_t;

    // Page table answer for the page under lookup
    typedef struct packed {
        logic  fault;
        page_t frame;
    } tpt_pt_resp_t;

    // Page number: the PAGE_BITS bits above the offset; bits past the
    // address field read as zero.
    function automatic page_t page_of(addr_t a);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(a);
        return w[OFFSET_BITS +: PAGE_BITS];
    endfunction

    // Physical address: frame above the offset, truncated to the address width.
    function automatic addr_t phys_of(page_t f, addr_t a);
        logic [WIDE_W-1:0] w;
        logic [WIDE_W-1:0] m;
        m = (WIDE_W'(1) << OFFSET_BITS) - WIDE_W'(1);
        w = (WIDE_W'(f) << OFFSET_BITS) | (WIDE_W'(a) & m);
        return w[ADDR_W-1:0];
    endfunction

endpackage

[rtl/tpt_cell.sv]
// ============================================================================
// tpt_cell
// One TLB entry of the shift chain: holds a page tag and its frame,
// compares the tag against the page under lookup, and passes its contents
// to the next cell whenever a new entry is inserted at the head.
// ============================================================================
module tpt_cell (
    input  logic                   aclk,
    input  logic                   shift_en,
    input  logic                   entry_valid,
    input  tpt_pkg::page_t         lookup_page,
    input  tpt_pkg::page_t         tag_in,
    input  tpt_pkg::page_t         frame_in,
    output tpt_pkg::page_t         tag_out,
    output tpt_pkg::page_t         frame_out,
    output tpt_pkg::tpt_cell_res_t res
);

    tpt_pkg::page_t tag_reg;
    tpt_pkg::page_t frame_reg;

    // Entry storage; contents move one cell down on every insert
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            tag_reg   <= tag_in;
            frame_reg <= frame_in;
        end
    end

    assign tag_out   = tag_reg;
    assign frame_out = frame_reg;

    // Tag compare, qualified by the occupancy of this cell
    always_comb begin
        res.match = entry_valid && (tag_reg == lookup_page);
        res.frame = frame_reg;
    end

endmodule

[rtl/tpt_page_table.sv]
// ============================================================================
// tpt_page_table
// Page table: frame map memory with a registered read port, a mapped bit per
// page cleared at reset, and the sequential frame allocator for faults.
// ============================================================================
module tpt_page_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  tpt_pkg::page_t        rd_page,
    input  tpt_pkg::page_t        lk_page,
    input  logic                  commit,
    output tpt_pkg::tpt_pt_resp_t resp
);

    tpt_pkg::page_t                     frame_mem [tpt_pkg::NUM_PAGES];
    tpt_pkg::page_t                     rd_data_reg;
    logic [tpt_pkg::NUM_PAGES-1:0]      mapped_reg;
    logic [tpt_pkg::NUM_PAGES-1:0]      mapped_next;
    tpt_pkg::free_t                     next_free_reg;
    tpt_pkg::free_t                     next_free_next;
    logic                               alloc;

    // Answer for the page under lookup
    always_comb begin
        resp.fault = !mapped_reg[lk_page];
        resp.frame = resp.fault ? next_free_reg[tpt_pkg::PAGE_BITS-1:0] : rd_data_reg;
    end

    assign alloc = commit && resp.fault;

    // Mapped bits and allocator; the counter saturates at the page count
    always_comb begin
        mapped_next    = mapped_reg;
        next_free_next = next_free_reg;
        if (alloc) begin
            mapped_next[lk_page] = 1'b1;
            if (next_free_reg < tpt_pkg::free_t'(tpt_pkg::NUM_PAGES)) begin
                next_free_next = next_free_reg + tpt_pkg::free_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapped_reg    <= '0;
            next_free_reg <= '0;
        end else begin
            mapped_reg    <= mapped_next;
            next_free_reg <= next_free_next;
        end
    end

    // Frame map write on a fault
    always_ff @(posedge aclk) begin
        if (alloc) begin
            frame_mem[lk_page] <= resp.frame;
        end
    end

    // Frame map read, issued when a transaction is accepted
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= frame_mem[rd_page];
        end
    end

    // Allocator never runs past the page count
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_free_reg <= tpt_pkg::free_t'(tpt_pkg::NUM_PAGES))
        else $error("frame allocator past page count");

    // A fault leaves the page mapped
    a_fault_maps: assert property (@(posedge aclk) disable iff (!aresetn)
        alloc |=> mapped_reg[$past(lk_page)])
        else $error("faulted page not marked mapped");

endmodule

[rtl/tlb_page_table_translate_unit.sv]
// ============================================================================
// tlb_page_table_translate_unit
// Logical to physical address translation through a FIFO-replaced TLB and a
// demand-paged page table.
// ============================================================================
// Each transaction passes through ST_IDLE, in which it is accepted and the
// page table read is launched, and ST_LOOKUP, in which the TLB cells
// compare their tags in parallel, the registered page table data is used on a
// miss, and the TLB, page table and frame allocator are updated. The
// registered read port of the page table memory is why lookup is a state of
// its own after acceptance. A new address is taken only after the previous
// lookup has finished; a result waiting at the output holds the lookup until
// it is taken. The TLB is a chain of cells: a miss inserts at the head and
// the oldest entry drops off the tail.
module tlb_page_table_translate_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          s_logical_addr,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          m_physical_addr,
    output logic                 m_tlb_hit,
    output logic                 m_page_fault
);

    localparam int N = tpt_pkg::TLB_ENTRIES;

    tpt_pkg::tpt_state_t    state_reg;
    tpt_pkg::tpt_state_t    state_next;
    tpt_pkg::addr_t         addr_reg;
    tpt_pkg::page_t         page_reg;
    tpt_pkg::fill_t         fill_reg;
    tpt_pkg::fill_t         fill_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    tpt_pkg::addr_t         m_phys_reg;
    logic                   m_hit_reg;
    logic                   m_fault_reg;

    logic                   accept;
    logic                   done;
    logic                   insert;
    logic                   hit;
    tpt_pkg::page_t         hit_frame;
    tpt_pkg::page_t         frame_sel;
    tpt_pkg::tpt_pt_resp_t  pt_resp;

    tpt_pkg::page_t         tag_chain   [N+1];
    tpt_pkg::page_t         frame_chain [N+1];
    tpt_pkg::tpt_cell_res_t cell_res    [N];

    assign accept = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg <= s_logical_addr;
            page_reg <= tpt_pkg::page_of(s_logical_addr);
        end
    end

    // TLB cell chain; head takes the page and frame being inserted
    assign tag_chain[0]   = page_reg;
    assign frame_chain[0] = frame_sel;

    for (genvar i = 0; i < N; i++) begin : g_cell
        tpt_cell u_cell (
            .aclk        (aclk),
            .shift_en    (insert),
            .entry_valid (fill_reg > tpt_pkg::fill_t'(i)),
            .lookup_page (page_reg),
            .tag_in      (tag_chain[i]),
            .frame_in    (frame_chain[i]),
            .tag_out     (tag_chain[i+1]),
            .frame_out   (frame_chain[i+1]),
            .res         (cell_res[i])
        );
    end

    // Hit merge; tags are unique, so an OR of matching frames is exact
    always_comb begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = 0; i < N; i++) begin
            hit       = hit | cell_res[i].match;
            hit_frame = hit_frame | (cell_res[i].match ? cell_res[i].frame : '0);
        end
    end

    // Page table
    tpt_page_table u_page_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_page (tpt_pkg::page_of(s_logical_addr)),
        .lk_page (page_reg),
        .commit  (insert),
        .resp    (pt_resp)
    );

    assign frame_sel = hit ? hit_frame : pt_resp.frame;

    // Control FSM
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        done         = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            tpt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = tpt_pkg::ST_LOOKUP;
                end
            end
            tpt_pkg::ST_LOOKUP: begin
                if (!m_valid_reg || m_ready) begin
                    done         = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = tpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tpt_pkg::ST_IDLE;
            end
        endcase
    end

    assign insert = done && !hit;

    // TLB occupancy
    always_comb begin
        fill_next = fill_reg;
        if (insert && (fill_reg < tpt_pkg::fill_t'(N))) begin
            fill_next = fill_reg + tpt_pkg::fill_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tpt_pkg::ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (done) begin
            m_phys_reg  <= tpt_pkg::phys_of(frame_sel, addr_reg);
            m_hit_reg   <= hit;
            m_fault_reg <= !hit && pt_resp.fault;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_physical_addr = m_phys_reg;
    assign m_tlb_hit       = m_hit_reg;
    assign m_page_fault    = m_fault_reg;

    // A result never reports both a hit and a fault
    a_hit_xor_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_tlb_hit && m_page_fault))
        else $error("hit and fault reported together");

    // Occupancy stays within the chain length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= tpt_pkg::fill_t'(N))
        else $error("TLB fill count overflow");

    // An accepted transaction always goes to lookup next
    a_accept_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == tpt_pkg::ST_LOOKUP))
        else $error("accepted transaction did not start lookup");

endmodule
